// ===== rtl/core/mipl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC/IP pair learning table - shared definitions
// Status codes, the beat that runs along the cell row, and the pair filter.
// ----------------------------------------------------------------------------
package mipl_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int MAC_W  = 48;
    localparam int IP_W   = 32;
    localparam int STAT_W = 3;
    localparam int IN_W   = 184;   // 180 bits of fields padded to whole bytes

    localparam logic [15:0]      ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [3:0]       IPV4_VERSION    = 4'd4;
    localparam logic [15:0]      SITE_PREFIX_RST = {8'd150, 8'd135};
    localparam logic [7:0]       OCTET_ONES      = 8'hff;
    localparam logic [MAC_W-1:0] MAC_ONES        = {MAC_W{1'b1}};
    localparam logic [MAC_W-1:0] MAC_ZERO        = '0;

    typedef logic [STAT_W-1:0] t_status;

    localparam t_status ST_NOT_IPV4 = 3'd0;
    localparam t_status ST_FILTERED = 3'd1;
    localparam t_status ST_KNOWN    = 3'd2;
    localparam t_status ST_ADDED    = 3'd3;
    localparam t_status ST_FULL     = 3'd4;

    // One pair on its way down the row. live: still looking for a match or
    // a free entry; once cleared, status is final.
    typedef struct packed {
        logic             valid;
        logic             is_dst;
        logic             live;
        t_status          status;
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
    } t_token;

    function automatic logic pair_filtered(input logic [MAC_W-1:0] mac,
                                           input logic [IP_W-1:0]  ip,
                                           input logic [15:0]      prefix);
        logic bad;
        bad = (mac == MAC_ONES) || (mac == MAC_ZERO) || (ip[31:16] != prefix) ||
              (ip[15:8] == OCTET_ONES) || (ip[7:0] == OCTET_ONES);
        return bad;
    endfunction

    function automatic t_token make_token(input logic             is_dst,
                                          input logic             ipv4,
                                          input logic [MAC_W-1:0] mac,
                                          input logic [IP_W-1:0]  ip,
                                          input logic [15:0]      prefix);
        t_token t;
        t.valid  = 1'b1;
        t.is_dst = is_dst;
        t.mac    = mac;
        t.ip     = ip;
        t.live   = 1'b0;
        t.status = ST_NOT_IPV4;
        if (ipv4) begin
            if (pair_filtered(mac, ip, prefix)) begin
                t.status = ST_FILTERED;
            end else begin
                t.live = 1'b1;
            end
        end
        return t;
    endfunction

endpackage

// ===== rtl/core/mipl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC/IP pair learning table - table cell
// Holds one entry; checks each passing beat against it, claims the entry for
// a live beat when still empty, and hands the beat on from its own register.
// ----------------------------------------------------------------------------
module mipl_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  mipl_pkg::t_token i_tok,
    output mipl_pkg::t_token o_tok
);
    import mipl_pkg::*;

    logic               r_valid;
    logic [MAC_W-1:0]   r_mac;
    logic [IP_W-1:0]    r_ip;
    t_token             r_tok;
    t_token             n_tok;
    logic               n_write;

    always_comb begin
        n_tok   = i_tok;
        n_write = 1'b0;
        if (i_tok.valid && i_tok.live) begin
            if (r_valid) begin
                if ((r_mac == i_tok.mac) && (r_ip == i_tok.ip)) begin
                    n_tok.live   = 1'b0;
                    n_tok.status = ST_KNOWN;
                end
            end else begin
                // entries fill in order, so the first empty cell ends the search
                n_write      = 1'b1;
                n_tok.live   = 1'b0;
                n_tok.status = ST_ADDED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_tok <= n_tok;
            if (n_write) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && n_write) begin
            r_mac <= i_tok.mac;
            r_ip  <= i_tok.ip;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/core/mac_ip_pair_learning_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC/IP pair learning table - top level
// Filters the source and destination pairs of each IPv4 header and learns
// new pairs into a row of cells; one status beat per header.
// ----------------------------------------------------------------------------
// The source and destination pairs of each accepted header enter the cell
// row as two beats, one per cycle, and travel one cell a cycle while the
// row is not held; the result then leaves through the output register. The
// next header is accepted while earlier ones are still in the row.
// A skid register takes one result while the output beat waits; the whole
// row holds while that skid register is full.
// Reset clears all entries, the entry count, and sets the prefix to 150.135.
// ----------------------------------------------------------------------------
module mac_ip_pair_learning_table #(
    parameter int TABLE_ENTRIES = mipl_pkg::TABLE_ENTRIES_DEF,
    parameter int CntW          = $clog2(TABLE_ENTRIES + 1),
    parameter int OutW          = ((2 * mipl_pkg::STAT_W + CntW + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // config: site prefix, first octet in upper byte
    input  logic                     i_cfg_we,
    input  logic [15:0]              i_cfg_wdata,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // ether_type[15:0], ver_nibble[19:16], src_mac[67:20], dst_mac[115:68],
    // src_ip[147:116], dst_ip[179:148], zero pad
    input  logic [mipl_pkg::IN_W-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // src_status[2:0], dst_status[5:3], entries_used[5+CntW:6], zero pad
    output logic [OutW-1:0]          m_axis_tdata
);
    import mipl_pkg::*;

    logic               en;
    logic               accept;
    logic               ipv4;
    logic               push;
    logic               take;
    t_token             src_tok;
    t_token             idle_tok;
    t_token             head_tok;
    t_token             w_tok [TABLE_ENTRIES+1];
    t_token             ex;
    t_status            ex_st;
    logic [CntW-1:0]    n_fill;

    logic [15:0]        r_prefix;
    logic               r_dst_pending;
    t_token             r_dst_tok;
    logic [CntW-1:0]    r_fill;
    logic               r_src_seen;
    logic               r_out_valid;
    logic               r_skid_valid;
    t_status            r_src_st;
    t_status            r_out_src;
    t_status            r_out_dst;
    logic [CntW-1:0]    r_out_cnt;
    t_status            r_skid_src;
    t_status            r_skid_dst;
    logic [CntW-1:0]    r_skid_cnt;

    // hold the whole row while the skid register holds a result
    assign en            = !r_skid_valid;
    assign s_axis_tready = i_rst_n && en && !r_dst_pending;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign ipv4 = (s_axis_tdata[15:0] == ETHERTYPE_IPV4) &&
                  (s_axis_tdata[19:16] == IPV4_VERSION);

    always_comb begin
        src_tok  = make_token(1'b0, ipv4, s_axis_tdata[67:20],
                              s_axis_tdata[147:116], r_prefix);
        idle_tok = src_tok;
        idle_tok.valid = 1'b0;
        if (r_dst_pending) begin
            head_tok = r_dst_tok;
        end else if (accept) begin
            head_tok = src_tok;
        end else begin
            head_tok = idle_tok;
        end
    end

    assign w_tok[0] = head_tok;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dst_tok <= make_token(1'b1, ipv4, s_axis_tdata[115:68],
                                    s_axis_tdata[179:148], r_prefix);
        end
    end

    genvar k;
    generate
        for (k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
            mipl_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_tok   (w_tok[k]),
                .o_tok   (w_tok[k+1])
            );
        end
    endgenerate

    // a beat still live at the end of the row found neither match nor room
    assign ex     = w_tok[TABLE_ENTRIES];
    assign ex_st  = ex.live ? ST_FULL : ex.status;
    assign n_fill = r_fill + CntW'(ex.valid && (ex_st == ST_ADDED));
    assign push   = en && ex.valid && ex.is_dst;
    assign take   = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix      <= SITE_PREFIX_RST;
            r_dst_pending <= 1'b0;
            r_fill        <= '0;
            r_src_seen    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_prefix <= i_cfg_wdata;
            end
            if (en) begin
                r_dst_pending <= r_dst_pending ? 1'b0 : s_axis_tvalid;
                r_fill        <= n_fill;
                if (ex.valid) begin
                    r_src_seen <= !ex.is_dst;
                end
            end
            if (!r_out_valid || take) begin
                r_out_valid <= r_skid_valid || push;
            end
            if (r_skid_valid) begin
                if (take) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (push && r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && ex.valid && !ex.is_dst) begin
            r_src_st <= ex_st;
        end
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_src <= r_skid_src;
                r_out_dst <= r_skid_dst;
                r_out_cnt <= r_skid_cnt;
            end else if (push) begin
                r_out_src <= r_src_st;
                r_out_dst <= ex_st;
                r_out_cnt <= n_fill;
            end
        end else if (push) begin
            // output beat still waiting: park the new result
            r_skid_src <= r_src_st;
            r_skid_dst <= ex_st;
            r_skid_cnt <= n_fill;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OutW'({r_out_cnt, r_out_dst, r_out_src});

    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CntW'(TABLE_ENTRIES))
        else $error("entry count above table size");

    a_pair_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && ex.valid && ex.is_dst) |-> r_src_seen)
        else $error("destination beat left the row without its source beat");

    a_dst_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_dst_pending)
        else $error("destination beat not queued after header accept");

    a_not_ipv4 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_src == ST_NOT_IPV4)) |-> (r_out_dst == ST_NOT_IPV4))
        else $error("mixed not-IPv4 status in one result");

endmodule

// ===== tb/tb_mac_ip_pair_learning_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC/IP pair learning table - testbench
// Streams parsed frame headers into the table and checks every status beat
// against a behavioral copy of the table kept in the bench. Covers non-IPv4
// frames, filtered pairs, known and new pairs, a full table, several site
// prefixes, random gaps on both sides and repeated long output stalls.
// ----------------------------------------------------------------------------
module tb_mac_ip_pair_learning_table;

    import mipl_pkg::*;

    localparam int TBL_DEPTH = TABLE_ENTRIES_DEF;
    localparam int IDX_W     = $clog2(TBL_DEPTH);
    localparam int LATENCY   = TBL_DEPTH + 2;

    typedef struct {
        logic [15:0]      ether_type;
        logic [3:0]       ver_nibble;
        logic [MAC_W-1:0] src_mac;
        logic [MAC_W-1:0] dst_mac;
        logic [IP_W-1:0]  src_ip;
        logic [IP_W-1:0]  dst_ip;
    } t_hdr;

    typedef struct {
        t_status    src_st;
        t_status    dst_st;
        logic [6:0] used;
    } t_learn_result;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [15:0]       i_cfg_wdata   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // ether_type, ver_nibble, src_mac, dst_mac, src_ip, dst_ip, zero pad
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // src_status, dst_status, entries_used, zero pad
    logic [15:0]       m_axis_tdata;

    mac_ip_pair_learning_table #(.TABLE_ENTRIES(TBL_DEPTH)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Table copy
    logic [MAC_W-1:0] tbl_mac [TBL_DEPTH];
    logic [IP_W-1:0]  tbl_ip  [TBL_DEPTH];
    logic [6:0]       tbl_fill   = '0;
    logic [15:0]      cur_prefix = SITE_PREFIX_RST;

    t_hdr             hdr_q [$];
    t_learn_result    result_q [$];
    logic [MAC_W-1:0] pool_mac [$];
    logic [IP_W-1:0]  pool_ip [$];

    int err_cnt = 0;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;

    function automatic int draw_gap(input bit on);
        int r;
        r = $urandom_range(0, 99);
        if (!on || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_status learn_pair(input logic [MAC_W-1:0] mac,
                                           input logic [IP_W-1:0]  ip);
        if (mac == MAC_ONES || mac == MAC_ZERO || ip[31:16] != cur_prefix ||
            ip[15:8] == OCTET_ONES || ip[7:0] == OCTET_ONES)
            return ST_FILTERED;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (i < tbl_fill && tbl_mac[i] == mac && tbl_ip[i] == ip)
                return ST_KNOWN;
        end
        if (tbl_fill >= TBL_DEPTH)
            return ST_FULL;
        tbl_mac[tbl_fill[IDX_W-1:0]] = mac;
        tbl_ip[tbl_fill[IDX_W-1:0]]  = ip;
        tbl_fill                     = tbl_fill + 7'd1;
        return ST_ADDED;
    endfunction

    function automatic void learn_header(input t_hdr h);
        t_learn_result r;
        r.src_st = ST_NOT_IPV4;
        r.dst_st = ST_NOT_IPV4;
        if (h.ether_type == ETHERTYPE_IPV4 && h.ver_nibble == IPV4_VERSION) begin
            r.src_st = learn_pair(h.src_mac, h.src_ip);
            r.dst_st = learn_pair(h.dst_mac, h.dst_ip);
        end
        r.used = tbl_fill;
        result_q.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    t_hdr cur_hdr;
    int   tx_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                learn_header(cur_hdr);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (hdr_q.size() > 0) begin
                    cur_hdr = hdr_q.pop_front();
                    s_axis_tdata <= {4'b0, cur_hdr.dst_ip, cur_hdr.src_ip,
                                     cur_hdr.dst_mac, cur_hdr.src_mac,
                                     cur_hdr.ver_nibble, cur_hdr.ether_type};
                    s_axis_tvalid <= 1'b1;
                    tx_gap = draw_gap(tx_idle);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and receiver stalls
    // ------------------------------------------------------------------
    int rx_gap      = 0;
    int hold_left   = 0;
    int seen_cnt    = 0;
    int next_hold   = 300;

    always @(posedge i_clk) begin
        t_learn_result e;
        bit took;
        took = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (took) begin
            seen_cnt++;
            if (result_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("tb: unexpected beat %h", m_axis_tdata);
            end else begin
                e = result_q.pop_front();
                if (m_axis_tdata[2:0] != e.src_st || m_axis_tdata[5:3] != e.dst_st ||
                    m_axis_tdata[12:6] != e.used) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("tb: beat %0d exp src=%0d dst=%0d used=%0d, got %0d %0d %0d",
                                 seen_cnt, e.src_st, e.dst_st, e.used,
                                 m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[12:6]);
                end
            end
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (seen_cnt >= next_hold) begin
            // long hold-off: let the row fill and push back on the input
            hold_left = 400;
            next_hold += 900;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (took)
                rx_gap = draw_gap(rx_idle);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_hdr(input logic [15:0] et, input logic [3:0] ver,
                            input logic [MAC_W-1:0] smac, input logic [IP_W-1:0] sip,
                            input logic [MAC_W-1:0] dmac, input logic [IP_W-1:0] dip);
        t_hdr h;
        h.ether_type = et;
        h.ver_nibble = ver;
        h.src_mac    = smac;
        h.src_ip     = sip;
        h.dst_mac    = dmac;
        h.dst_ip     = dip;
        hdr_q.push_back(h);
    endtask

    task automatic wait_idle();
        while (hdr_q.size() > 0 || s_axis_tvalid || result_q.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic pick_pair(output logic [MAC_W-1:0] mac, output logic [IP_W-1:0] ip);
        logic [63:0] w;
        logic [7:0]  o3;
        logic [7:0]  o4;
        int          r;
        int          k;
        w  = {$urandom, $urandom};
        o3 = 8'($urandom_range(0, 254));
        o4 = 8'($urandom_range(0, 254));
        mac = w[MAC_W-1:0];
        ip  = {cur_prefix, o3, o4};
        r   = $urandom_range(0, 99);
        if (r < 66 && pool_mac.size() > 0) begin
            k   = $urandom_range(0, pool_mac.size() - 1);
            mac = pool_mac[k];
            ip  = pool_ip[k];
        end else if (r < 70 || (r < 66 && pool_mac.size() == 0)) begin
            // fresh learnable pair, remembered for later hits
            pool_mac.push_back(mac);
            pool_ip.push_back(ip);
        end else if (r < 78) begin
            mac = r[0] ? MAC_ONES : MAC_ZERO;
        end else if (r < 86) begin
            ip = $urandom;
        end else if (r < 93) begin
            if (r[0]) ip[15:8] = OCTET_ONES;
            else      ip[7:0]  = OCTET_ONES;
        end else begin
            ip = $urandom;
        end
    endtask

    task automatic run_phase(input logic [15:0] prefix, input int n_items, input bit idle_on);
        logic [MAC_W-1:0] smac;
        logic [MAC_W-1:0] dmac;
        logic [IP_W-1:0]  sip;
        logic [IP_W-1:0]  dip;
        logic [15:0]      et;
        logic [3:0]       ver;
        int               r;
        wait_idle();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= prefix;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_prefix = prefix;
        pool_mac.delete();
        pool_ip.delete();
        tx_idle = idle_on;
        rx_idle = idle_on;
        for (int n = 0; n < n_items; n++) begin
            pick_pair(smac, sip);
            pick_pair(dmac, dip);
            et  = ETHERTYPE_IPV4;
            ver = IPV4_VERSION;
            r   = $urandom_range(0, 99);
            if (r >= 96) begin
                et  = 16'($urandom);
                ver = 4'($urandom);
            end else if (r >= 93) begin
                ver = 4'($urandom);
            end else if (r >= 90) begin
                et = 16'($urandom);
            end
            push_hdr(et, ver, smac, sip, dmac, dip);
        end
    endtask

    initial begin
        logic [IP_W-1:0] ok_ip;
        ok_ip = {SITE_PREFIX_RST, 8'd1, 8'd2};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset prefix, register untouched
        push_hdr(16'h86dd, IPV4_VERSION, 48'h1, ok_ip, 48'h2, ok_ip);
        push_hdr(ETHERTYPE_IPV4, 4'd6, 48'h1, ok_ip, 48'h2, ok_ip);
        push_hdr(16'hffff, 4'hf, MAC_ONES, 32'hffffffff, MAC_ONES, 32'hffffffff);
        push_hdr(16'h0000, 4'h0, MAC_ZERO, 32'h0, MAC_ZERO, 32'h0);
        push_hdr(ETHERTYPE_IPV4, IPV4_VERSION, 48'h0a0b0c0d0e0f, ok_ip,
                 48'h102030405060, {SITE_PREFIX_RST, 8'd3, 8'd4});
        push_hdr(ETHERTYPE_IPV4, IPV4_VERSION, 48'h0a0b0c0d0e0f, ok_ip,
                 48'h102030405060, {SITE_PREFIX_RST, 8'd3, 8'd4});
        // same new pair as source and destination
        push_hdr(ETHERTYPE_IPV4, IPV4_VERSION, 48'haaaa55550001, {SITE_PREFIX_RST, 16'h0505},
                 48'haaaa55550001, {SITE_PREFIX_RST, 16'h0505});
        push_hdr(ETHERTYPE_IPV4, IPV4_VERSION, MAC_ONES, ok_ip, MAC_ZERO, ok_ip);
        push_hdr(ETHERTYPE_IPV4, IPV4_VERSION, 48'h1, {~SITE_PREFIX_RST, 16'h0102},
                 48'h1, {SITE_PREFIX_RST, OCTET_ONES, 8'd1});
        push_hdr(ETHERTYPE_IPV4, IPV4_VERSION, 48'h1, {SITE_PREFIX_RST, 8'd1, OCTET_ONES},
                 48'h1, {SITE_PREFIX_RST, 8'hfe, 8'hfe});
        push_hdr(ETHERTYPE_IPV4, IPV4_VERSION, 48'h1, {SITE_PREFIX_RST, 16'h0000},
                 48'hfffffffffffe, {SITE_PREFIX_RST, 8'hfe, 8'hfe});
        // same hardware address, other IP
        push_hdr(ETHERTYPE_IPV4, IPV4_VERSION, 48'h1, {SITE_PREFIX_RST, 16'h0001},
                 48'h800000000000, {SITE_PREFIX_RST, 16'h7f80});
        push_hdr(ETHERTYPE_IPV4, 4'h5, 48'h1, ok_ip, 48'h2, ok_ip);

        run_phase(16'h0000, 400, 1'b1);
        run_phase(16'hffff, 400, 1'b1);
        run_phase(SITE_PREFIX_RST, 500, 1'b0);
        run_phase(16'($urandom), 650, 1'b1);

        wait_idle();
        repeat (LATENCY + 4) @(posedge i_clk);
        if (err_cnt == 0 && result_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
